>>> rtl/core/rlss_pkg.sv
// Shared constants for the random looping shift sequencer.
package rlss_pkg;

    // Default width of the shift register.
    localparam int REG_BITS_DEFAULT = 16;

    // Field widths.
    localparam int MODE_W      = 2;
    localparam int LEN_W       = 5;
    localparam int LEVEL_W     = 12;
    localparam int RND_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_MODE      = 2'd0;
    localparam logic [1:0] REG_LENGTH    = 2'd1;
    localparam logic [1:0] REG_LOW_THR   = 2'd2;
    localparam logic [1:0] REG_HIGH_THR  = 2'd3;

    // Feedback modes.
    localparam logic [MODE_W-1:0] MODE_INVERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_COIN   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RARE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_LOCKED = 2'd3;

    // Register values after reset.
    localparam logic [LEN_W-1:0]          LENGTH_RESET   = 5'd16;
    localparam logic signed [LEVEL_W-1:0] LOW_THR_RESET  = 12'sd0;
    localparam logic signed [LEVEL_W-1:0] HIGH_THR_RESET = 12'sd100;

endpackage

>>> rtl/core/random_looping_shift_sequencer_core.sv
// Random looping shift sequencer: trigger, rotating loop, skid output and APB registers.
//
// Usage:
//   Input stream (s_*): one transfer per clock-input sample. tdata holds the
//   signed clock level, four random bits and the write button.
//   Output stream (m_*): exactly one transfer per input transfer, in order,
//   carrying the gate bit, the advanced flag and the register contents.
//   APB port: mode, loop length and the two trigger thresholds; write only
//   while no transfer is in flight.
// Output and throughput:
//   Results are registered in the output register, or the skid register during a
//   stall. One input transfer is taken every cycle while s_tready is high; the
//   trigger and loop state update in the same cycle that the sample is taken.
// Reset:
//   rst_n clears the shift register, disarms the trigger, empties the output
//   stages and loads the register defaults (locked loop, length 16,
//   thresholds 0 and 100).
// Stall:
//   A two-entry output (output register plus skid register) lets one more
//   input transfer in while the receiver holds tready low; s_tready drops
//   only once both entries are full.
module random_looping_shift_sequencer_core #(
    parameter int REG_BITS = rlss_pkg::REG_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // Input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [11:0] clock_sample, [15:12] random_bits, [16] write_zero, [23:17] zero
    input  logic [rlss_pkg::IN_DATA_W-1:0]    s_tdata,
    // Output stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] gate, [1] advanced, [9:2] seq_byte, [25:10] seq_word, [31:26] zero
    output logic [rlss_pkg::OUT_DATA_W-1:0]   m_tdata,
    // Configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rlss_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [rlss_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [rlss_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int LW = $clog2(REG_BITS + 1);
    localparam int WW = (REG_BITS > rlss_pkg::WORD_W) ? REG_BITS : rlss_pkg::WORD_W;
    localparam int RES_W = 2 + rlss_pkg::BYTE_W + rlss_pkg::WORD_W;

    // Configuration registers
    logic [rlss_pkg::MODE_W-1:0]          mode_reg;
    logic [rlss_pkg::LEN_W-1:0]           length_reg;
    logic signed [rlss_pkg::LEVEL_W-1:0]  low_thr_reg;
    logic signed [rlss_pkg::LEVEL_W-1:0]  high_thr_reg;

    // Sequencer state
    logic [REG_BITS-1:0] shift_reg;
    logic [REG_BITS-1:0] shift_next;
    logic                trig_reg;
    logic                trig_next;

    // Output stages
    logic [RES_W-1:0] out_reg;
    logic             out_valid_reg;
    logic [RES_W-1:0] skid_reg;
    logic             skid_valid_reg;

    logic                                 in_xfer;
    logic                                 out_xfer;
    logic                                 cfg_wr;
    logic signed [rlss_pkg::LEVEL_W-1:0]  level;
    logic [rlss_pkg::RND_W-1:0]           rnd;
    logic                                 wr_zero;
    logic                                 rise;
    logic                                 hot;
    logic [LW-1:0]                        len_eff;
    logic [WW-1:0]                        wide;
    logic [RES_W-1:0]                     result;

    assign level   = s_tdata[rlss_pkg::LEVEL_W-1:0];
    assign rnd     = s_tdata[rlss_pkg::LEVEL_W +: rlss_pkg::RND_W];
    assign wr_zero = s_tdata[rlss_pkg::LEVEL_W + rlss_pkg::RND_W];

    assign s_tready = !skid_valid_reg;
    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = rlss_pkg::OUT_DATA_W'(out_reg);

    // Schmitt trigger: re-arm at or below low, fire at or above high.
    always_comb
    begin
        trig_next = trig_reg;
        rise      = 1'b0;
        if (trig_reg)
        begin
            if (level <= low_thr_reg)
                trig_next = 1'b0;
        end
        else if (level >= high_thr_reg)
        begin
            trig_next = 1'b1;
            rise      = 1'b1;
        end
    end

    // Fed-back bit
    always_comb
    begin
        hot = shift_reg[0];
        if (wr_zero)
            hot = 1'b0;
        else
        begin
            case (mode_reg)
                rlss_pkg::MODE_INVERT: hot = !shift_reg[0];
                rlss_pkg::MODE_COIN:   hot = shift_reg[0] ^ rnd[0];
                rlss_pkg::MODE_RARE:   hot = shift_reg[0] ^ (&rnd);
                default:               hot = shift_reg[0];
            endcase
        end
    end

    // Clamp the loop length into 1..REG_BITS.
    always_comb
    begin
        if (length_reg == '0)
            len_eff = LW'(1);
        else if (32'(length_reg) > REG_BITS)
            len_eff = LW'(REG_BITS);
        else
            len_eff = LW'(length_reg);
    end

    // On a trigger rise, rotate the loop bits right by one through the fed-back bit; bits above the loop hold.
    always_comb
    begin
        shift_next = shift_reg;
        if (rise)
        begin
            for (int i = 0; i < REG_BITS; i++)
            begin
                if (i + 1 < 32'(len_eff))
                    shift_next[i] = shift_reg[(i + 1) % REG_BITS];
                else if (i + 1 == 32'(len_eff))
                    shift_next[i] = hot;
            end
        end
    end

    assign wide   = WW'(shift_next);
    assign result = {wide[rlss_pkg::WORD_W-1:0], wide[rlss_pkg::BYTE_W-1:0],
                     rise, shift_reg[0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= '0;
            trig_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            shift_reg <= shift_next;
            trig_reg  <= trig_next;
        end
    end

    // Output register with skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || out_xfer)
            begin
                out_valid_reg  <= skid_valid_reg || in_xfer;
                skid_valid_reg <= 1'b0;
            end
            else if (in_xfer)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_xfer)
            out_reg <= skid_valid_reg ? skid_reg : result;
        else if (in_xfer)
            skid_reg <= result;
    end

    // APB registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rlss_pkg::MODE_LOCKED;
            length_reg   <= rlss_pkg::LENGTH_RESET;
            low_thr_reg  <= rlss_pkg::LOW_THR_RESET;
            high_thr_reg <= rlss_pkg::HIGH_THR_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                rlss_pkg::REG_MODE:     mode_reg     <= pwdata[rlss_pkg::MODE_W-1:0];
                rlss_pkg::REG_LENGTH:   length_reg   <= pwdata[rlss_pkg::LEN_W-1:0];
                rlss_pkg::REG_LOW_THR:  low_thr_reg  <= pwdata[rlss_pkg::LEVEL_W-1:0];
                rlss_pkg::REG_HIGH_THR: high_thr_reg <= pwdata[rlss_pkg::LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            rlss_pkg::REG_MODE:     prdata = rlss_pkg::APB_DATA_W'(mode_reg);
            rlss_pkg::REG_LENGTH:   prdata = rlss_pkg::APB_DATA_W'(length_reg);
            rlss_pkg::REG_LOW_THR:  prdata = rlss_pkg::APB_DATA_W'(low_thr_reg);
            rlss_pkg::REG_HIGH_THR: prdata = rlss_pkg::APB_DATA_W'(high_thr_reg);
            default:                prdata = '0;
        endcase
    end

endmodule
